// ===== hdl/bbsm_pkg.sv =====
// bbsm_pkg: constants, request and state codes and the result type for the
// bucketed binary search match core; used by bbsm_ctrl and the top-level core
`timescale 1ns / 1ps

package bbsm_pkg;

  localparam int unsigned INDEX_BASES = 6;
  localparam int unsigned BASE_BITS   = 2;
  localparam int unsigned KEY_BASES   = 20;
  localparam int unsigned DATA_DEPTH  = 65536;

  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned KEY_W   = 40;
  localparam int unsigned START_W = 17;

  localparam int unsigned BUCKET_BITS  = INDEX_BASES * BASE_BITS;
  localparam int unsigned BUCKET_COUNT = 1 << BUCKET_BITS;
  localparam int unsigned BUCKET_DEPTH = BUCKET_COUNT + 1;
  localparam int unsigned BUCKET_AW    = $clog2(BUCKET_DEPTH);
  localparam int unsigned BUCKET_SHIFT = (KEY_BASES - INDEX_BASES) * BASE_BITS;
  localparam int unsigned DATA_AW      = $clog2(DATA_DEPTH);
  localparam int unsigned POS_W        = (DATA_AW + 1 > START_W) ? DATA_AW + 1 : START_W;

  localparam int unsigned S_FIELDS_W = ADDR_W + KEY_W + KEY_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_FIELDS_W = KEY_W + ADDR_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [TYPE_W-1:0] {
    REQ_SORTED = 2'd0,
    REQ_BUCKET = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_GUIDE  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_PROBE,
    ST_STEP,
    ST_LAST,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] pos;
    logic [KEY_W-1:0]  key;
  } result_t;

endpackage

// ===== hdl/bbsm_ram.sv =====
// bbsm_ram: generic simple dual-port synchronous ram, one write and one read
// port, read data registered; no dependencies
`timescale 1ns / 1ps

module bbsm_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bbsm_ctrl.sv =====
// bbsm_ctrl: request decode, bucket lookup and lower-bound search sequencer
// driving the bucket and sorted-key rams; depends on bbsm_pkg
`timescale 1ns / 1ps

module bbsm_ctrl import bbsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [TYPE_W-1:0]    req_type_i,
  input  logic [ADDR_W-1:0]    req_addr_i,
  input  logic [KEY_W-1:0]     req_value_i,
  input  logic [KEY_W-1:0]     req_key_i,
  output logic                 bkt_we_o,
  output logic [BUCKET_AW-1:0] bkt_waddr_o,
  output logic [START_W-1:0]   bkt_wdata_o,
  output logic                 bkt_re_o,
  output logic [BUCKET_AW-1:0] bkt_raddr_o,
  input  logic [START_W-1:0]   bkt_rdata_i,
  output logic                 data_we_o,
  output logic [DATA_AW-1:0]   data_waddr_o,
  output logic [KEY_W-1:0]     data_wdata_o,
  output logic                 data_re_o,
  output logic [DATA_AW-1:0]   data_raddr_o,
  input  logic [KEY_W-1:0]     data_rdata_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output result_t              res_o
);

  state_e                 state_q, state_d;
  logic [KEY_W-1:0]       key_q;
  logic [BUCKET_BITS-1:0] bkt_idx_q;
  logic [POS_W-1:0]       lo_q, hi_q, end_q, mid_q;
  result_t                res_q;

  req_type_e        req_type;
  logic             accept;
  logic [POS_W-1:0] hi_raw, hi_clamp, mid;

  assign req_type = req_type_e'(req_type_i);
  assign accept   = req_valid_i && (state_q == ST_IDLE);
  assign hi_raw   = POS_W'(bkt_rdata_i);
  assign hi_clamp = (hi_raw > POS_W'(DATA_DEPTH)) ? POS_W'(DATA_DEPTH) : hi_raw;
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_type == REQ_QUERY) begin
            state_d = ST_LO;
          end else if (req_type == REQ_GUIDE) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_LO: state_d = ST_HI;
      ST_HI: state_d = (lo_q >= hi_clamp) ? ST_IDLE : ST_PROBE;
      ST_PROBE: begin
        priority if (lo_q < hi_q) begin
          state_d = ST_STEP;
        end else if (lo_q >= end_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_STEP: state_d = ST_PROBE;
      ST_LAST: state_d = (data_rdata_i == key_q) ? ST_EMIT : ST_IDLE;
      ST_EMIT: state_d = res_ready_i ? ST_IDLE : ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory and handshake outputs
  always_comb begin
    req_ready_o  = (state_q == ST_IDLE);
    bkt_we_o     = accept && (req_type == REQ_BUCKET)
                   && (POS_W'(req_addr_i) <= POS_W'(BUCKET_COUNT));
    bkt_waddr_o  = BUCKET_AW'(req_addr_i);
    bkt_wdata_o  = req_value_i[START_W-1:0];
    data_we_o    = accept && (req_type == REQ_SORTED)
                   && (POS_W'(req_addr_i) < POS_W'(DATA_DEPTH));
    data_waddr_o = DATA_AW'(req_addr_i);
    data_wdata_o = req_value_i;
    bkt_re_o     = 1'b0;
    bkt_raddr_o  = BUCKET_AW'(req_key_i[BUCKET_SHIFT +: BUCKET_BITS]);
    data_re_o    = 1'b0;
    data_raddr_o = DATA_AW'(mid);
    res_valid_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: bkt_re_o = accept && (req_type == REQ_QUERY);
      ST_LO: begin
        bkt_re_o    = 1'b1;
        bkt_raddr_o = BUCKET_AW'(bkt_idx_q) + BUCKET_AW'(1);
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          data_re_o = 1'b1;
        end else begin
          data_re_o    = (lo_q < end_q);
          data_raddr_o = DATA_AW'(lo_q);
        end
      end
      ST_EMIT: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        key_q     <= req_key_i;
        bkt_idx_q <= req_key_i[BUCKET_SHIFT +: BUCKET_BITS];
        res_q.key <= req_key_i;
        res_q.pos <= '0;
      end
      ST_LO: lo_q <= POS_W'(bkt_rdata_i);
      ST_HI: begin
        hi_q  <= hi_clamp;
        end_q <= hi_clamp;
      end
      ST_PROBE: mid_q <= mid;
      ST_STEP: begin
        if (data_rdata_i < key_q) begin
          lo_q <= mid_q + POS_W'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      ST_LAST: begin
        res_q.key <= key_q;
        res_q.pos <= ADDR_W'(lo_q);
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

// ===== hdl/bucketed_binary_search_match_core.sv =====
// Load items write sorted 40-bit keys or bucket start positions into two
// on-chip rams; a query reads its bucket's start and end, then runs a
// lower-bound binary search over the sorted-key ram with one read per probe.
// The search loop alternates a probe state, which issues the read at the
// midpoint, and a step state, which compares and narrows the range, on the
// single sorted-key read port.
// Results are held in an output register, so a new item is taken while a
// result waits. Depends on bbsm_pkg, bbsm_ram and bbsm_ctrl.
`timescale 1ns / 1ps

module bucketed_binary_search_match_core import bbsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // table_address, table_value, query_key
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [TYPE_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // matched_key, match_position
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic                 bkt_we, bkt_re, data_we, data_re;
  logic [BUCKET_AW-1:0] bkt_waddr, bkt_raddr;
  logic [START_W-1:0]   bkt_wdata, bkt_rdata;
  logic [DATA_AW-1:0]   data_waddr, data_raddr;
  logic [KEY_W-1:0]     data_wdata, data_rdata;
  logic                 res_valid, res_ready;
  result_t              res;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  bbsm_ram #(
    .DEPTH (BUCKET_DEPTH),
    .WIDTH (START_W)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  bbsm_ram #(
    .DEPTH (DATA_DEPTH),
    .WIDTH (KEY_W)
  ) u_sorted_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (data_re),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  bbsm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .req_addr_i   (s_axis_tdata[ADDR_W-1:0]),
    .req_value_i  (s_axis_tdata[ADDR_W +: KEY_W]),
    .req_key_i    (s_axis_tdata[ADDR_W + KEY_W +: KEY_W]),
    .bkt_we_o     (bkt_we),
    .bkt_waddr_o  (bkt_waddr),
    .bkt_wdata_o  (bkt_wdata),
    .bkt_re_o     (bkt_re),
    .bkt_raddr_o  (bkt_raddr),
    .bkt_rdata_i  (bkt_rdata),
    .data_we_o    (data_we),
    .data_waddr_o (data_waddr),
    .data_wdata_o (data_wdata),
    .data_re_o    (data_re),
    .data_raddr_o (data_raddr),
    .data_rdata_i (data_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q);

endmodule
